@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

@@ rtl/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and codes of the circular deque: command and status codes, item
// structs of both channels and the controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdq_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	// Command codes; codes above CMD_QUERY act as a query
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] push_value;
	} cdq_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] popped_value;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
		logic [OCC_W-1:0]         occupancy;
		logic                     is_empty;
		logic                     is_full;
	} cdq_rsp_t;

	typedef enum logic {
		CDQ_IDLE,
		CDQ_POP
	} cdq_state_t;

endpackage

@@ rtl/cdq_ram.sv @@
// ----------------------------------------------------------------------------
// cdq_ram
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_ram import cdq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/cdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdq_ctrl
// Deque controller: head and tail indices, word count, cached front and rear
// words, and the sequencer that reads the new end word after a pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cdq_req_t          req,
	output logic              res_valid,
	input  logic              res_ready,
	output cdq_rsp_t          res,
	output logic              we,
	output logic [AW-1:0]     waddr,
	output logic [DATA_W-1:0] wdata,
	output logic              re,
	output logic [AW-1:0]     raddr,
	input  logic [DATA_W-1:0] rdata
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cdq_state_t state_q, state_d;
	logic [AW-1:0] head_q, head_d, tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic signed [DATA_W-1:0] front_q, front_d, rear_q, rear_d;
	logic signed [DATA_W-1:0] popped_q, popped_d, popped_w;
	logic pop_front_q, pop_front_d;
	logic [STAT_W-1:0] status_w;
	logic [AW-1:0] head_next, head_prev, tail_next, tail_prev;
	logic is_full_now, is_empty_now, is_push;

	// Ring neighbors of both ends
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

	assign is_full_now  = (count_q == FULL_CNT);
	assign is_empty_now = (count_q == '0);
	assign is_push      = (req.cmd == CMD_PUSH_FRONT);

	assign req_ready = (state_q == CDQ_IDLE) && res_ready;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CDQ_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// Cached end words and pending pop data
	always_ff @(posedge clk) begin
		front_q     <= front_d;
		rear_q      <= rear_d;
		popped_q    <= popped_d;
		pop_front_q <= pop_front_d;
	end

	// Decode the command, update indices, drive the memory ports
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		front_d     = front_q;
		rear_d      = rear_q;
		popped_d    = popped_q;
		pop_front_d = pop_front_q;
		popped_w    = '0;
		status_w    = ST_DONE;
		res_valid   = 1'b0;
		we          = 1'b0;
		waddr       = head_q;
		wdata       = $unsigned(req.push_value);
		re          = 1'b0;
		raddr       = head_next;
		case (state_q)
			CDQ_IDLE: begin
				if (req_valid && req_ready) begin
					res_valid = 1'b1;
					case (req.cmd)
						CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
							if (is_full_now) begin
								status_w = ST_FULL;
							end else if (is_empty_now) begin
								// First word always lands in slot zero
								head_d  = '0;
								tail_d  = '0;
								we      = 1'b1;
								waddr   = '0;
								front_d = req.push_value;
								rear_d  = req.push_value;
								count_d = count_q + 1'b1;
							end else if (is_push) begin
								head_d  = head_prev;
								we      = 1'b1;
								waddr   = head_prev;
								front_d = req.push_value;
								count_d = count_q + 1'b1;
							end else begin
								tail_d  = tail_next;
								we      = 1'b1;
								waddr   = tail_next;
								rear_d  = req.push_value;
								count_d = count_q + 1'b1;
							end
						end
						CMD_POP_FRONT, CMD_POP_REAR: begin
							if (is_empty_now) begin
								status_w = ST_EMPTY;
							end else if (count_q == CW'(1)) begin
								// Last word leaves; indices keep their values
								popped_w = (req.cmd == CMD_POP_FRONT) ? front_q : rear_q;
								count_d  = '0;
							end else begin
								// Fetch the new end word, finish next cycle
								res_valid   = 1'b0;
								re          = 1'b1;
								count_d     = count_q - 1'b1;
								state_d     = CDQ_POP;
								pop_front_d = (req.cmd == CMD_POP_FRONT);
								if (req.cmd == CMD_POP_FRONT) begin
									popped_d = front_q;
									head_d   = head_next;
									raddr    = head_next;
								end else begin
									popped_d = rear_q;
									tail_d   = tail_prev;
									raddr    = tail_prev;
								end
							end
						end
						default: begin
							status_w = ST_DONE;
						end
					endcase
				end
			end
			CDQ_POP: begin
				res_valid = 1'b1;
				popped_w  = popped_q;
				if (pop_front_q) begin
					front_d = $signed(rdata);
				end else begin
					rear_d = $signed(rdata);
				end
				if (res_ready) begin
					state_d = CDQ_IDLE;
				end
			end
			default: begin
				state_d = CDQ_IDLE;
			end
		endcase
	end

	// Result fields describe the deque after the command
	always_comb begin
		res.status       = status_w;
		res.popped_value = popped_w;
		res.front_value  = (count_d == '0) ? '0 : front_d;
		res.rear_value   = (count_d == '0) ? '0 : rear_d;
		res.occupancy    = OCC_W'(count_d);
		res.is_empty     = (count_d == '0);
		res.is_full      = (count_d == FULL_CNT);
	end

endmodule

@@ rtl/circular_deque.sv @@
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words in a ring of DEPTH slots, with
// push and pop at both ends and a query command.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+------------------
//   command | req_valid | req_ready | req (cdq_req_t)
//   result  | rsp_valid | rsp_ready | rsp (cdq_rsp_t)
//
// Pushes, queries, rejected commands and the pop of the last word finish in
// the cycle they are taken. A pop that leaves words behind reads the new end
// word from the registered slot RAM and forms its result in the cycle after.
// Reset clears indices and count at once; slots need no clearing pass.
// A command is taken while the output register is empty or being drained;
// input stalls otherwise, and while a pop waits for its new end word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circular_deque import cdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  cdq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output cdq_rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);

	logic              res_valid, res_ready;
	cdq_rsp_t          res;
	logic              we, re;
	logic [AW-1:0]     waddr, raddr;
	logic [DATA_W-1:0] wdata, rdata;
	logic              out_valid_q;
	cdq_rsp_t          out_q;

	cdq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	cdq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Output register: load a new item when empty or being drained
	assign res_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Checks on controller behavior
	`ASSERT_NEVER(a_res_dropped, clk, arst_n, res_valid && !res_ready && req_ready)
	`ASSERT_NEVER(a_full_and_empty, clk, arst_n, res_valid && res.is_full && res.is_empty)
	`ASSERT_PROP(a_reject_full, clk, arst_n, (res_valid && res.status == ST_FULL) |-> res.is_full)
	`ASSERT_PROP(a_no_write_on_read, clk, arst_n, re |-> !we)

endmodule

@@ bench/circular_deque_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking bench for the circular deque. A mirror of the ring, kept in
// a small class, predicts every result from the accepted commands. Results
// are checked field by field in order. Stimulus is a directed opening
// (empty and full edges, each named command, spare codes) then random traffic
// that swings between filling and draining, with random stalls on both
// channels.
// ----------------------------------------------------------------------------

module circular_deque_tb;
	import cdq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int IDLE_PCT     = 7;
	localparam int RANDOM_ITEMS = 850;
	localparam int STALL_LIMIT  = 2000;

	localparam logic [CMD_W-1:0]  CMD_SPARE_LO = CMD_QUERY + 3'd1;
	localparam logic [CMD_W-1:0]  CMD_SPARE_HI = '1;
	localparam logic [DATA_W-1:0] WORD_MAX     = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] WORD_MIN     = 32'h8000_0000;

	// Mirror of the ring: predicts the result of each command
	class deque_mirror;
		logic [DATA_W-1:0] ring [DEPTH];
		int head;
		int tail;
		bit empty;
		int failures;
		cdq_rsp_t expected_results[$];

		function new();
			head = 0;
			tail = 0;
			empty = 1'b1;
			failures = 0;
		endfunction

		function int ring_next(int i);
			return (i + 1) % DEPTH;
		endfunction

		function int ring_prev(int i);
			return (i + DEPTH - 1) % DEPTH;
		endfunction

		function bit ring_full();
			return !empty && head == ring_next(tail);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Apply one accepted command and queue the result it must produce
		function void note_command(cdq_req_t item);
			cdq_rsp_t want;
			int count;
			want = '0;
			want.status = ST_DONE;
			case (item.cmd)
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (ring_full()) begin
					want.status = ST_FULL;
				end else if (empty) begin
					head = 0;
					tail = 0;
					ring[0] = item.push_value;
					empty = 1'b0;
				end else if (item.cmd == CMD_PUSH_FRONT) begin
					head = ring_prev(head);
					ring[head] = item.push_value;
				end else begin
					tail = ring_next(tail);
					ring[tail] = item.push_value;
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR: begin
				if (empty) begin
					want.status = ST_EMPTY;
				end else if (item.cmd == CMD_POP_FRONT) begin
					want.popped_value = ring[head];
					if (head == tail)
						empty = 1'b1;
					else
						head = ring_next(head);
				end else begin
					want.popped_value = ring[tail];
					if (head == tail)
						empty = 1'b1;
					else
						tail = ring_prev(tail);
				end
			end
			default: ;
			endcase
			count = empty ? 0 : ((tail + DEPTH - head) % DEPTH) + 1;
			want.front_value = empty ? '0 : ring[head];
			want.rear_value  = empty ? '0 : ring[tail];
			want.occupancy   = OCC_W'(count);
			want.is_empty    = empty;
			want.is_full     = ring_full();
			expected_results.push_back(want);
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(cdq_rsp_t got);
			cdq_rsp_t want;
			if (expected_results.size() == 0) begin
				$error("result item arrived with no prediction pending");
				failures++;
				return;
			end
			want = expected_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				failures++;
			end
			if (got.popped_value !== want.popped_value) begin
				$error("popped_value: expected %0d, got %0d",
					want.popped_value, got.popped_value);
				failures++;
			end
			if (got.front_value !== want.front_value) begin
				$error("front_value: expected %0d, got %0d",
					want.front_value, got.front_value);
				failures++;
			end
			if (got.rear_value !== want.rear_value) begin
				$error("rear_value: expected %0d, got %0d",
					want.rear_value, got.rear_value);
				failures++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, got %0d",
					want.occupancy, got.occupancy);
				failures++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
				failures++;
			end
			if (got.is_full !== want.is_full) begin
				$error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
				failures++;
			end
		endfunction
	endclass

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	cdq_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	cdq_rsp_t rsp;
	logic     quiet     = 1'b0;
	int       idle_cycles = 0;

	deque_mirror mirror;

	circular_deque #(
		.DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #6 clk = ~clk;

	// Stall the result channel at random, except in the quiet stretch
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			mirror.check_result(rsp);
	end

	// End the run when no handshake happens for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("circular_deque regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one command, with a random gap first; return at its acceptance
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
		cdq_req_t item;
		item.cmd = cmd;
		item.push_value = value;
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		mirror.note_command(item);
	endtask

	// Hold off the command channel until every predicted result is in
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (mirror.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 15))
		0: return WORD_MAX;
		1: return WORD_MIN;
		2: return '0;
		3: return '1;
		default: return $urandom();
		endcase
	endfunction

	initial begin
		int push_share;
		int roll;
		logic [CMD_W-1:0] cmd;

		mirror = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rejected pops and a spare code on an empty deque
		send_command(CMD_POP_FRONT, WORD_MAX);
		send_command(CMD_POP_REAR, WORD_MIN);
		send_command(CMD_SPARE_LO, '1);
		// Push into empty, then pop the last word from either end
		send_command(CMD_PUSH_FRONT, WORD_MAX);
		send_command(CMD_POP_REAR, '0);
		send_command(CMD_PUSH_REAR, WORD_MIN);
		send_command(CMD_POP_FRONT, '0);
		// Fill from both ends, wrapping the head below slot 0
		for (int k = 0; k < DEPTH; k++) begin
			send_command(k[0] ? CMD_PUSH_REAR : CMD_PUSH_FRONT,
				(k == 2) ? '1 : (k == 3) ? '0 : $urandom());
		end
		// Rejected pushes and queries on a full deque
		send_command(CMD_PUSH_FRONT, WORD_MIN);
		send_command(CMD_PUSH_REAR, WORD_MAX);
		send_command(CMD_QUERY, $urandom());
		send_command(CMD_SPARE_HI, $urandom());
		drain();

		// Random traffic in phases that lean toward filling, draining or neither
		push_share = 46;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
				0: push_share = 70;
				1: push_share = 20;
				default: push_share = 46;
				endcase
			end
			if (i == RANDOM_ITEMS / 2)
				quiet <= 1'b1;
			if (i == RANDOM_ITEMS / 2 + 150)
				quiet <= 1'b0;
			roll = $urandom_range(0, 99);
			if (roll < 8)
				cmd = CMD_QUERY + CMD_W'($urandom_range(0, 3));
			else if (roll < 8 + push_share)
				cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
			else
				cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
			send_command(cmd, pick_word());
			if (i == RANDOM_ITEMS / 4 || i == 3 * RANDOM_ITEMS / 4)
				drain();
		end

		// Wait out the last results plus the pop latency
		req_valid <= 1'b0;
		@(posedge clk);
		while (mirror.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mirror.failures == 0 && mirror.pending() == 0)
			$display("circular_deque regression: pass");
		else
			$display("circular_deque regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_ctrl.sv
rtl/circular_deque.sv
bench/circular_deque_tb.sv
